/* hdl/bmc_pkg.sv */
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LINE_BITS   = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int KIND_W      = 2;
  localparam int ENTRY_W     = KIND_W + LINE_BITS;
  localparam int OUT_LINE_W  = 16;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_OPEN_BRC  = 8'h7B;
  localparam logic [7:0] CH_OPEN_PAR  = 8'h28;
  localparam logic [7:0] CH_OPEN_SQR  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_BRC = 8'h7D;
  localparam logic [7:0] CH_CLOSE_PAR = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQR = 8'h5D;

  localparam logic [KIND_W-1:0] KIND_BRC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SQR = 2'd2;

  typedef enum logic [2:0] {
    EV_OPEN     = 3'd0,
    EV_MATCHED  = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_EMPTY    = 3'd3,
    EV_UNCLOSED = 3'd4,
    EV_SUCCESS  = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_kind_t;

  typedef struct packed {
    event_kind_t           kind;
    logic [7:0]            symbol;
    logic [OUT_LINE_W-1:0] symbol_line;
    logic [7:0]            open_symbol;
    logic [OUT_LINE_W-1:0] open_line;
    logic                  last;
  } result_t;

  function automatic logic [7:0] open_char(input logic [KIND_W-1:0] kind);
    logic [7:0] ch;
    unique case (kind)
      KIND_BRC: ch = CH_OPEN_BRC;
      KIND_PAR: ch = CH_OPEN_PAR;
      KIND_SQR: ch = CH_OPEN_SQR;
      default:  ch = CH_OPEN_BRC;
    endcase
    return ch;
  endfunction

  function automatic logic [OUT_LINE_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+OUT_LINE_W-1:0] ext;
    ext = {{OUT_LINE_W{1'b0}}, v};
    return ext[OUT_LINE_W-1:0];
  endfunction

endpackage

/* hdl/bmc_ram.sv */
`timescale 1ns / 1ps

module bmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bracket_match_checker.sv */
`timescale 1ns / 1ps
// Results are registered; a result that meets a stalled output waits in ST_EMIT. A closing
// bracket needs a stack memory read first, so its result is registered in ST_CLOSE from the
// read data. Plain bytes and newlines are taken one item per cycle, opening brackets likewise
// while the output is free, and a closing bracket blocks new input until its result is loaded.
// End of text with open brackets pops them in ST_POP, one memory read per unclosed result.
// Synchronous reset clears depth, error flag and line count (to one), but not the stack memory.
module bracket_match_checker
  import bmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [7:0]  symbol,
  output logic [15:0] symbol_line,
  output logic [7:0]  open_symbol,
  output logic [15:0] open_line,
  output logic        last_result
);

  typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_CLOSE, ST_POP} state_t;

  localparam logic [DEPTH_W-1:0]   FULL_DEPTH = DEPTH_W'(STACK_DEPTH);
  localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE   = LINE_BITS'(1);

  state_t               state;
  logic [DEPTH_W-1:0]   depth;
  logic [LINE_BITS-1:0] line;
  logic                 error_seen;
  logic [7:0]           c_reg;
  logic [KIND_W-1:0]    close_kind_reg;
  result_t              res;
  result_t              pend;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [DEPTH_W-1:0]   depth_m1;
  logic [DEPTH_W-1:0]   depth_m2;
  logic                 is_open;
  logic                 is_close;
  logic [KIND_W-1:0]    open_kind;
  logic [KIND_W-1:0]    close_kind;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [KIND_W-1:0]    top_kind;
  logic [LINE_BITS-1:0] top_line;
  logic                 idle_emit;
  result_t              idle_res;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((accept && idle_emit) || (state == ST_EMIT) ||
                                 (state == ST_CLOSE) || (state == ST_POP));
  assign depth_m1 = depth - DEPTH_W'(1);
  assign depth_m2 = depth - DEPTH_W'(2);
  assign top_kind = rd_data[ENTRY_W-1 -: KIND_W];
  assign top_line = rd_data[LINE_BITS-1:0];

  always_comb begin
    is_open    = 1'b0;
    is_close   = 1'b0;
    open_kind  = KIND_BRC;
    close_kind = KIND_BRC;
    unique case (text_byte)
      CH_OPEN_BRC:  begin is_open = 1'b1;  open_kind = KIND_BRC; end
      CH_OPEN_PAR:  begin is_open = 1'b1;  open_kind = KIND_PAR; end
      CH_OPEN_SQR:  begin is_open = 1'b1;  open_kind = KIND_SQR; end
      CH_CLOSE_BRC: begin is_close = 1'b1; close_kind = KIND_BRC; end
      CH_CLOSE_PAR: begin is_close = 1'b1; close_kind = KIND_PAR; end
      CH_CLOSE_SQR: begin is_close = 1'b1; close_kind = KIND_SQR; end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = accept && !end_of_text && !error_seen && is_open && (depth != FULL_DEPTH);
    wr_addr = depth[ADDR_W-1:0];
    wr_data = {open_kind, line};
    rd_en   = 1'b0;
    rd_addr = depth_m1[ADDR_W-1:0];
    if (accept && !error_seen && (depth != '0) && (end_of_text || is_close)) begin
      rd_en = 1'b1;
    end
    if ((state == ST_POP) && out_free && (depth_m1 != '0)) begin
      rd_en   = 1'b1;
      rd_addr = depth_m2[ADDR_W-1:0];
    end
  end

  always_comb begin
    idle_emit = 1'b0;
    idle_res  = '0;
    idle_res.symbol      = text_byte;
    idle_res.symbol_line = line_out(line);
    if (end_of_text) begin
      if (!error_seen && (depth == '0)) begin
        idle_emit   = 1'b1;
        idle_res    = '0;
        idle_res.kind = EV_SUCCESS;
        idle_res.last = 1'b1;
      end
    end else if (!error_seen) begin
      if (is_open) begin
        idle_emit     = 1'b1;
        idle_res.kind = (depth == FULL_DEPTH) ? EV_OVERFLOW : EV_OPEN;
      end else if (is_close && (depth == '0)) begin
        idle_emit     = 1'b1;
        idle_res.kind = EV_EMPTY;
      end
    end
  end

  bmc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      depth      <= '0;
      line       <= LINE_ONE;
      error_seen <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            c_reg          <= text_byte;
            close_kind_reg <= close_kind;
            if (idle_emit) begin
              if (out_free) begin
                res       <= idle_res;
                out_valid <= 1'b1;
              end else begin
                pend  <= idle_res;
                state <= ST_EMIT;
              end
            end
            if (end_of_text) begin
              if (error_seen || (depth == '0)) begin
                depth      <= '0;
                line       <= LINE_ONE;
                error_seen <= 1'b0;
              end else begin
                state <= ST_POP;
              end
            end else if (!error_seen) begin
              if (text_byte == CH_NEWLINE) begin
                if (line != LINE_MAX) begin
                  line <= line + LINE_ONE;
                end
              end else if (is_open) begin
                if (depth == FULL_DEPTH) begin
                  error_seen <= 1'b1;
                end else begin
                  depth <= depth + DEPTH_W'(1);
                end
              end else if (is_close) begin
                if (depth == '0) begin
                  error_seen <= 1'b1;
                end else begin
                  depth <= depth_m1;
                  state <= ST_CLOSE;
                end
              end
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res       <= pend;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_CLOSE: begin
          if (out_free) begin
            res.kind        <= (top_kind == close_kind_reg) ? EV_MATCHED : EV_MISMATCH;
            res.symbol      <= c_reg;
            res.symbol_line <= line_out(line);
            res.open_symbol <= open_char(top_kind);
            res.open_line   <= line_out(top_line);
            res.last        <= 1'b0;
            out_valid       <= 1'b1;
            if (top_kind != close_kind_reg) begin
              error_seen <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_POP: begin
          if (out_free) begin
            res.kind        <= EV_UNCLOSED;
            res.symbol      <= open_char(top_kind);
            res.symbol_line <= line_out(top_line);
            res.open_symbol <= '0;
            res.open_line   <= '0;
            res.last        <= (depth_m1 == '0);
            out_valid       <= 1'b1;
            depth           <= depth_m1;
            if (depth_m1 == '0) begin
              line       <= LINE_ONE;
              error_seen <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign event_kind  = res.kind;
  assign symbol      = res.symbol;
  assign symbol_line = res.symbol_line;
  assign open_symbol = res.open_symbol;
  assign open_line   = res.open_line;
  assign last_result = res.last;

endmodule

/* hdl/bmc_checker.sv */
`timescale 1ns / 1ps

module bmc_checker
  import bmc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  text_byte,
  input logic        end_of_text,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [7:0]  symbol,
  input logic [15:0] symbol_line,
  input logic [7:0]  open_symbol,
  input logic [15:0] open_line,
  input logic        last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(symbol)
      && $stable(symbol_line) && $stable(last_result))
    else $error("A stalled result item changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result item is offered right after reset.");

  a_success_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_SUCCESS) |->
      last_result && (symbol == 8'd0) && (symbol_line == 16'd0))
    else $error("A success item carries a symbol or lacks the final flag.");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_result |->
      (event_kind == EV_SUCCESS) || (event_kind == EV_UNCLOSED))
    else $error("The final flag is set on an item not caused by end of text.");

  a_open_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != EV_MATCHED) && (event_kind != EV_MISMATCH) |->
      (open_symbol == 8'd0) && (open_line == 16'd0))
    else $error("An item without a popped bracket carries opening bracket fields.");

endmodule

bind bracket_match_checker bmc_checker u_bmc_checker (.*);
